// File: rtl/core/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types and constants of the band-pass FIR filter: field widths,
// action codes, controller states and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TAP_W         = 18;
  localparam int PROD_W        = SAMPLE_W + TAP_W;
  localparam int FRAC_BITS     = 14;
  localparam int TAP_IDX_W     = 5;
  localparam int TAP_COUNT_W   = 6;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd29;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_accept;
    logic sample_accept;
    logic mac_issue;
    logic mac_last;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_busy;
  } dp_status_t;

endpackage

// File: rtl/core/bpf_dp.sv
// ----------------------------------------------------------------------------
// bpf_dp
// Datapath: tap memory, circular sample memory, multiply-accumulate pipeline
// and the registered output stage with floor shift and saturation.
// ----------------------------------------------------------------------------
module bpf_dp #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpf_pkg::dp_cmd_t                    cmd,
  output bpf_pkg::dp_status_t                 status,
  input  logic        [bpf_pkg::TAP_IDX_W-1:0] tap_index,
  input  logic signed [bpf_pkg::TAP_W-1:0]    low_tap,
  input  logic signed [bpf_pkg::TAP_W-1:0]    high_tap,
  input  logic signed [bpf_pkg::SAMPLE_W-1:0] sample,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic signed [bpf_pkg::SAMPLE_W-1:0] filtered,
  output logic                                clipped
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int ACC_W = bpf_pkg::PROD_W + $clog2(MAX_TAPS);
  localparam int Q_W   = ACC_W - bpf_pkg::FRAC_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  logic signed [bpf_pkg::TAP_W-1:0]    tap_mem   [MAX_TAPS];
  logic signed [bpf_pkg::SAMPLE_W-1:0] delay_mem [MAX_TAPS];

  logic [AW-1:0] wp, wp_inc, rd_ptr, tap_ptr;
  logic signed [bpf_pkg::TAP_W:0]      diff;
  logic signed [bpf_pkg::TAP_W-1:0]    band_tap;
  logic                                tap_in_range;
  logic signed [bpf_pkg::SAMPLE_W-1:0] dl_q;
  logic signed [bpf_pkg::TAP_W-1:0]    tp_q;
  logic signed [bpf_pkg::PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]             acc;
  logic signed [Q_W-1:0]               q;
  logic                                q_fits;
  logic v1, last1, v2, last2, acc_done;

  assign wp_inc = (wp == LAST_ADDR) ? '0 : wp + 1'b1;

  assign diff = {high_tap[bpf_pkg::TAP_W-1], high_tap} - {low_tap[bpf_pkg::TAP_W-1], low_tap};
  always_comb begin
    if (diff[bpf_pkg::TAP_W] == diff[bpf_pkg::TAP_W-1]) begin
      band_tap = diff[bpf_pkg::TAP_W-1:0];
    end else if (diff[bpf_pkg::TAP_W]) begin
      band_tap = {1'b1, {(bpf_pkg::TAP_W-1){1'b0}}};
    end else begin
      band_tap = {1'b0, {(bpf_pkg::TAP_W-1){1'b1}}};
    end
  end
  assign tap_in_range = 32'(tap_index) < MAX_TAPS;

  always_ff @(posedge clk) begin
    if (cmd.load_accept && tap_in_range) begin
      tap_mem[AW'(tap_index)] <= band_tap;
    end
    if (cmd.sample_accept) begin
      delay_mem[wp_inc] <= sample;
    end
    if (cmd.mac_issue) begin
      dl_q <= delay_mem[rd_ptr];
      tp_q <= tap_mem[tap_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rd_ptr  <= '0;
      tap_ptr <= '0;
    end else if (cmd.sample_accept) begin
      wp      <= wp_inc;
      rd_ptr  <= wp_inc;
      tap_ptr <= '0;
    end else if (cmd.mac_issue) begin
      rd_ptr  <= (rd_ptr == '0) ? LAST_ADDR : rd_ptr - 1'b1;
      tap_ptr <= tap_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      last1    <= 1'b0;
      v2       <= 1'b0;
      last2    <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      v1       <= cmd.mac_issue;
      last1    <= cmd.mac_last;
      v2       <= v1;
      last2    <= last1;
      acc_done <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= dl_q * tp_q;
    end
    if (cmd.sample_accept) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor shift, then saturate when the upper bits are not a sign run
  assign q      = acc[ACC_W-1:bpf_pkg::FRAC_BITS];
  assign q_fits = (q[Q_W-1:bpf_pkg::SAMPLE_W-1] == '0) || (q[Q_W-1:bpf_pkg::SAMPLE_W-1] == '1);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      clipped <= !q_fits;
      if (q_fits) begin
        filtered <= q[bpf_pkg::SAMPLE_W-1:0];
      end else if (q[Q_W-1]) begin
        filtered <= {1'b1, {(bpf_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
        filtered <= {1'b0, {(bpf_pkg::SAMPLE_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.acc_done = acc_done;
  assign status.out_busy = m_tvalid && !m_tready;

endmodule

// File: rtl/core/bpf_ctrl.sv
// ----------------------------------------------------------------------------
// bpf_ctrl
// Controller: tap count register, warm-up counter and the sequencer that
// steps the multiply-accumulate over the taps in use.
// ----------------------------------------------------------------------------
module bpf_ctrl #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bpf_pkg::TAP_COUNT_W-1:0]     cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic                                action,
  output bpf_pkg::dp_cmd_t                    cmd,
  input  bpf_pkg::dp_status_t                 status
);

  localparam int CW = $clog2(MAX_TAPS + 1);

  bpf_pkg::state_t state, state_next;
  logic [bpf_pkg::TAP_COUNT_W-1:0] tap_count;
  logic [CW-1:0] n_eff, cnt, cnt_next, samples_seen;
  logic accept;

  always_comb begin
    if (tap_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(tap_count);
    end
  end

  assign s_tready = (state == bpf_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= bpf_pkg::TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept && action == bpf_pkg::ACTION_SAMPLE
                 && samples_seen != CW'(MAX_TAPS)) begin
      samples_seen <= samples_seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      bpf_pkg::ST_IDLE: begin
        if (accept) begin
          if (action == bpf_pkg::ACTION_LOAD) begin
            cmd.load_accept = 1'b1;
          end else begin
            cmd.sample_accept = 1'b1;
            if (samples_seen >= n_eff) begin
              state_next = bpf_pkg::ST_MAC;
              cnt_next   = '0;
            end
          end
        end
      end
      bpf_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_last  = (cnt == n_eff - 1'b1);
        cnt_next      = cnt + 1'b1;
        if (cmd.mac_last) begin
          state_next = bpf_pkg::ST_DRAIN;
        end
      end
      bpf_pkg::ST_DRAIN: begin
        if (status.acc_done) begin
          if (!status.out_busy) begin
            cmd.out_load = 1'b1;
            state_next   = bpf_pkg::ST_IDLE;
          end else begin
            state_next = bpf_pkg::ST_EMIT;
          end
        end
      end
      bpf_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = bpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpf_pkg::ST_IDLE;
      end
    endcase
  end

  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    state == bpf_pkg::ST_MAC |-> cnt < n_eff)
    else $error("tap counter ran past the taps in use");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result loaded over a pending item");

  a_warmup: assert property (@(posedge clk) disable iff (rst)
    cmd.sample_accept && samples_seen != CW'(MAX_TAPS)
    |=> samples_seen == $past(samples_seen) + 1'b1)
    else $error("sample count not advanced");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == bpf_pkg::ST_DRAIN |=> state == bpf_pkg::ST_DRAIN
      || state == bpf_pkg::ST_EMIT || state == bpf_pkg::ST_IDLE)
    else $error("bad exit from drain");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    status.acc_done |-> state == bpf_pkg::ST_DRAIN)
    else $error("sum finished outside drain");

endmodule

// File: rtl/core/bandpass_fir_filter_top.sv
// ----------------------------------------------------------------------------
// bandpass_fir_filter_top
// Streaming band-pass FIR filter, signed 16-bit samples, Q3.14 taps.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_*. s_tuser = 0 loads tap tap_index with
//   high_tap - low_tap (saturated to 18 bits); s_tuser = 1 delivers a sample.
//   A sample yields a result on m_* once n samples (n = taps in use) were seen
//   before it: sum of delay*tap over the taps in use, shifted right 14 (floor),
//   saturated to 16 bits, m_tuser flags saturation.
//   Loads and warm-up samples are accepted in idle. A result-producing sample
//   runs one multiply-accumulate per tap in use through the single multiplier,
//   fed by one read port of each memory, then passes the read, product and
//   accumulate stages; no new item is taken until its result is loaded into
//   the output register.
//   cfg_we/cfg_wdata write tap_count (reset 29); write only while idle.
//   Reset clears the sample count and pointers and sets tap_count to 29;
//   tap memory is undefined until loaded. No clearing pass is needed.
//   A stalled receiver holds the result in the output register; loads and
//   warm-up samples are still accepted, one more result-producing sample is
//   computed, then the block waits for m_tready.
// ----------------------------------------------------------------------------
module bandpass_fir_filter_top #(
  parameter int MAX_TAPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // tap_index[4:0], low_tap[22:5], high_tap[40:23],
                                 // sample[56:41], zero fill
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // filtered[15:0]
  output logic        m_tuser    // clipped
);

  bpf_pkg::dp_cmd_t    cmd;
  bpf_pkg::dp_status_t status;

  logic        [bpf_pkg::TAP_IDX_W-1:0] tap_index;
  logic signed [bpf_pkg::TAP_W-1:0]     low_tap, high_tap;
  logic signed [bpf_pkg::SAMPLE_W-1:0]  sample, filtered;

  assign tap_index = s_tdata[4:0];
  assign low_tap   = s_tdata[22:5];
  assign high_tap  = s_tdata[40:23];
  assign sample    = s_tdata[56:41];
  assign m_tdata   = filtered;

  bpf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .action    (s_tuser),
    .cmd       (cmd),
    .status    (status)
  );

  bpf_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .tap_index (tap_index),
    .low_tap   (low_tap),
    .high_tap  (high_tap),
    .sample    (sample),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .filtered  (filtered),
    .clipped   (m_tuser)
  );

endmodule

// File: verif/bandpass_fir_filter_checker.sv
// ----------------------------------------------------------------------------
// bandpass_fir_filter_checker
// Watches the input, output and configuration ports of the band-pass FIR
// filter. It keeps its own copy of the tap memory, delay line, sample count
// and tap count, and queues the result due for each accepted result-producing
// sample. Each result item is then compared field by field with the oldest
// queued one. Mismatches and results that nobody asked for are counted.
// ----------------------------------------------------------------------------
module bandpass_fir_filter_checker #(
  parameter int MAX_TAPS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpf_pkg::TAP_COUNT_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [63:0]                     s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bpf_pkg::SAMPLE_W-1:0]    m_tdata,
  input  logic                            m_tuser,
  output int                              fail_count,
  output int                              pending
);

  localparam longint TAP_HI = (longint'(1) <<< (bpf_pkg::TAP_W - 1)) - 1;
  localparam longint TAP_LO = -(longint'(1) <<< (bpf_pkg::TAP_W - 1));
  localparam longint OUT_HI = (longint'(1) <<< (bpf_pkg::SAMPLE_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (bpf_pkg::SAMPLE_W - 1));

  typedef struct packed {
    logic [bpf_pkg::SAMPLE_W-1:0] filtered;
    logic                         clipped;
  } filter_out_t;

  filter_out_t                         filtered_q[$];
  logic signed [bpf_pkg::TAP_W-1:0]    band_taps  [MAX_TAPS];
  logic signed [bpf_pkg::SAMPLE_W-1:0] delay_line [MAX_TAPS];
  int                                  samples_seen;
  logic [bpf_pkg::TAP_COUNT_W-1:0]     tap_count;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic run_filter(input logic action, input logic [63:0] data);
    logic [bpf_pkg::TAP_IDX_W-1:0]       idx;
    logic signed [bpf_pkg::TAP_W-1:0]    low_tap;
    logic signed [bpf_pkg::TAP_W-1:0]    high_tap;
    logic signed [bpf_pkg::SAMPLE_W-1:0] smp;
    longint                              diff;
    longint                              acc;
    longint                              q;
    int                                  n;
    filter_out_t                         res;
    idx      = data[4:0];
    low_tap  = data[22:5];
    high_tap = data[40:23];
    smp      = data[56:41];
    if (action == bpf_pkg::ACTION_LOAD) begin
      diff = longint'(high_tap) - longint'(low_tap);
      if (diff > TAP_HI) diff = TAP_HI;
      else if (diff < TAP_LO) diff = TAP_LO;
      if (idx < MAX_TAPS) band_taps[idx] = diff[bpf_pkg::TAP_W-1:0];
    end else begin
      n = int'(tap_count);
      if (n < 1) n = 1;
      if (n > MAX_TAPS) n = MAX_TAPS;
      for (int i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = smp;
      if (samples_seen < n) begin
        samples_seen++;
      end else begin
        if (samples_seen < MAX_TAPS) samples_seen++;
        acc = 0;
        for (int i = 0; i < n; i++) acc += longint'(delay_line[i]) * longint'(band_taps[i]);
        q = acc >>> bpf_pkg::FRAC_BITS;
        res.clipped = 1'b0;
        if (q > OUT_HI) begin
          q = OUT_HI;
          res.clipped = 1'b1;
        end else if (q < OUT_LO) begin
          q = OUT_LO;
          res.clipped = 1'b1;
        end
        res.filtered = q[bpf_pkg::SAMPLE_W-1:0];
        filtered_q.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    filter_out_t want;
    if (rst) begin
      tap_count    = bpf_pkg::TAP_COUNT_RESET;
      samples_seen = 0;
      foreach (delay_line[i]) delay_line[i] = '0;
      filtered_q.delete();
    end else begin
      if (cfg_we) tap_count = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: filtered=%0d clipped=%0b",
                     $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (m_tdata !== want.filtered || m_tuser !== want.clipped) begin
            if (fail_count < 10)
              $display("mismatch: filtered exp %0d got %0d, clipped exp %0b got %0b",
                       $signed(want.filtered), $signed(m_tdata), want.clipped, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) run_filter(s_tuser, s_tdata);
    end
    pending = filtered_q.size();
  end

endmodule

// File: verif/bandpass_fir_filter_top_tb.sv
// ----------------------------------------------------------------------------
// bandpass_fir_filter_top_tb
// Drives the band-pass FIR filter with a short directed sequence (saturating
// tap differences, full-scale and clipping samples, warm-up, zero tap count)
// and then random phases: each picks a tap count, loads the taps in use and
// streams samples with occasional tap reloads. Bursty input and a changing
// output stall pattern; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module bandpass_fir_filter_top_tb;

  localparam int  N_ITEMS     = 1500;
  localparam int  SETTLE_CYC  = 40;
  localparam int  CYCLE_LIMIT = 1500000;

  localparam logic [bpf_pkg::TAP_W-1:0]    TAP_MAX_V = 18'h1FFFF;
  localparam logic [bpf_pkg::TAP_W-1:0]    TAP_MIN_V = 18'h20000;
  localparam logic [bpf_pkg::SAMPLE_W-1:0] SMP_MAX_V = 16'h7FFF;
  localparam logic [bpf_pkg::SAMPLE_W-1:0] SMP_MIN_V = 16'h8000;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [bpf_pkg::TAP_COUNT_W-1:0] cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [63:0]                     s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [bpf_pkg::SAMPLE_W-1:0]    m_tdata;
  logic                            m_tuser;

  int fail_count;
  int pending;
  int item_count  = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  bandpass_fir_filter_top #(.MAX_TAPS(32)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  bandpass_fir_filter_checker #(.MAX_TAPS(32)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output stall pattern: always ready, coin flip, mostly ready, mostly stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) != 0);
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_item(input logic act, input logic [bpf_pkg::TAP_IDX_W-1:0] idx,
                           input logic [bpf_pkg::TAP_W-1:0] lo,
                           input logic [bpf_pkg::TAP_W-1:0] hi,
                           input logic [bpf_pkg::SAMPLE_W-1:0] smp);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'b0, smp, hi, lo, idx};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    burst_left--;
    item_count++;
  endtask

  task automatic send_load(input logic [bpf_pkg::TAP_IDX_W-1:0] idx,
                           input logic [bpf_pkg::TAP_W-1:0] lo,
                           input logic [bpf_pkg::TAP_W-1:0] hi);
    send_item(bpf_pkg::ACTION_LOAD, idx, lo, hi, bpf_pkg::SAMPLE_W'($urandom));
  endtask

  task automatic send_sample(input logic [bpf_pkg::SAMPLE_W-1:0] smp);
    send_item(bpf_pkg::ACTION_SAMPLE, bpf_pkg::TAP_IDX_W'($urandom),
              bpf_pkg::TAP_W'($urandom), bpf_pkg::TAP_W'($urandom), smp);
  endtask

  // drain: a trailing load or warm-up sample may still be in flight
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_tap_count(input logic [bpf_pkg::TAP_COUNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [bpf_pkg::TAP_W-1:0] rand_tap(input bit wide);
    int v;
    v = $urandom_range(0, 32767) - 16384;
    return wide ? bpf_pkg::TAP_W'($urandom) : v[bpf_pkg::TAP_W-1:0];
  endfunction

  function automatic logic [bpf_pkg::SAMPLE_W-1:0] rand_sample();
    int v;
    v = $urandom_range(0, 2047) - 1024;
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 3))
           0: return SMP_MAX_V;
           1: return SMP_MIN_V;
           2: return '0;
           default: return '1;
         endcase
      1: return v[bpf_pkg::SAMPLE_W-1:0];
      default: return bpf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int tc;
    int n_eff;
    bit wide;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = bpf_pkg::ACTION_LOAD;
    m_tready  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // warm-up only under the reset tap count
    send_sample(SMP_MAX_V);
    send_sample(SMP_MIN_V);
    send_sample(16'h0001);

    set_tap_count(6'd1);
    send_load(5'd0, TAP_MIN_V, TAP_MAX_V);
    send_sample(SMP_MAX_V);
    send_sample(SMP_MIN_V);
    send_sample(SMP_MAX_V);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_load(5'd0, TAP_MAX_V, TAP_MIN_V);
    send_sample(SMP_MIN_V);
    send_sample(16'd5);
    send_load(5'd0, 18'd100, 18'd100);
    send_sample(16'd12345);
    send_load(5'd0, 18'd0, 18'd16384);
    send_sample(SMP_MAX_V);
    send_sample(SMP_MIN_V);

    set_tap_count(6'd0);
    send_sample(16'd1234);
    send_sample(-16'sd1234);

    while (item_count < N_ITEMS) begin
      case ($urandom_range(0, 7))
        0: tc = 0;
        1: tc = 1;
        2: tc = 32;
        3: tc = $urandom_range(33, 63);
        4, 5: tc = 2 * $urandom_range(0, 15) + 1;
        default: tc = $urandom_range(1, 32);
      endcase
      n_eff = (tc == 0) ? 1 : (tc > 32) ? 32 : tc;
      set_tap_count(tc[bpf_pkg::TAP_COUNT_W-1:0]);
      wide = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n_eff; i++)
        send_load(i[bpf_pkg::TAP_IDX_W-1:0], rand_tap(wide), rand_tap(wide));
      repeat ($urandom_range(10, 70)) begin
        if ($urandom_range(0, 11) == 0)
          send_load(bpf_pkg::TAP_IDX_W'($urandom), rand_tap(wide), rand_tap(wide));
        else
          send_sample(rand_sample());
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
